@@ src/stctp_pkg.sv @@
package stctp_pkg;

  // Coordinate and internal widths (all exact, no rounding before the divide)
  localparam int CW   = 32;             // Q16.16 coordinate
  localparam int DW   = CW + 1;         // vertex/point difference
  localparam int PW   = 2 * DW;         // product of two differences
  localparam int SW   = PW + 2;         // sum of three products (dot)
  localparam int XW   = PW + 1;         // cross product component
  localparam int LW   = 32;             // low limb of a split operand
  localparam int HW   = XW - LW;        // signed high limb of a cross component
  localparam int PPW  = 2 * HW;         // partial product of two split limbs
  localparam int TW   = 2 * XW;         // one term of a triple product
  localparam int WW   = TW + 2;         // triple product / barycentric weight / denominator
  localparam int EW   = SW + 1;         // edge denominator
  localparam int NL   = (WW + LW - 1) / LW;   // limbs of a weight
  localparam int NW   = WW + DW + 1;    // numerator of the final divide
  localparam int QB   = CW + 1;         // quotient bits kept before saturation
  localparam int QW   = QB + 1;         // signed quotient
  localparam int RW   = 31;             // radius register
  localparam int RSQW = 2 * RW;         // squared radius

  // Pipeline depths
  localparam int FRONT_LAT = 8;
  localparam int AXIS_LAT  = QB + 7;
  localparam int HIT_LAT   = 3;
  localparam int TOTAL_LAT = FRONT_LAT + AXIS_LAT + HIT_LAT;

  // Region codes
  localparam logic [2:0] REG_VA   = 3'd0;
  localparam logic [2:0] REG_VB   = 3'd1;
  localparam logic [2:0] REG_VC   = 3'd2;
  localparam logic [2:0] REG_EAB  = 3'd3;
  localparam logic [2:0] REG_EBC  = 3'd4;
  localparam logic [2:0] REG_ECA  = 3'd5;
  localparam logic [2:0] REG_FACE = 3'd6;

  typedef struct packed {
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
    logic signed [CW-1:0] vert_a_x;
    logic signed [CW-1:0] vert_a_y;
    logic signed [CW-1:0] vert_a_z;
    logic signed [CW-1:0] vert_b_x;
    logic signed [CW-1:0] vert_b_y;
    logic signed [CW-1:0] vert_b_z;
    logic signed [CW-1:0] vert_c_x;
    logic signed [CW-1:0] vert_c_y;
    logic signed [CW-1:0] vert_c_z;
  } query_t;

  typedef struct packed {
    logic signed [CW-1:0] closest_x;
    logic signed [CW-1:0] closest_y;
    logic signed [CW-1:0] closest_z;
    logic [2:0]           region;
    logic                 hit;
  } result_t;

  // One axis of closest = base + (w1*d1 + w2*d2) / den
  typedef struct packed {
    logic signed [WW-1:0] w1;
    logic signed [WW-1:0] w2;
    logic signed [WW-1:0] den;
    logic signed [DW-1:0] d1;
    logic signed [DW-1:0] d2;
    logic signed [CW-1:0] base;
  } axis_t;

  typedef struct packed {
    logic [2:0]          region;
    logic [2:0][CW-1:0]  point;
    axis_t [2:0]         ax;
  } front_t;

endpackage

@@ src/stctp_front.sv @@
module stctp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  stctp_pkg::query_t   query,
  output logic                out_valid,
  output stctp_pkg::front_t   out
);

  localparam int CW  = stctp_pkg::CW;
  localparam int DW  = stctp_pkg::DW;
  localparam int PW  = stctp_pkg::PW;
  localparam int SW  = stctp_pkg::SW;
  localparam int XW  = stctp_pkg::XW;
  localparam int LW  = stctp_pkg::LW;
  localparam int PPW = stctp_pkg::PPW;
  localparam int TW  = stctp_pkg::TW;
  localparam int WW  = stctp_pkg::WW;
  localparam int EW  = stctp_pkg::EW;

  // difference vectors
  localparam int V_AB = 0;
  localparam int V_AC = 1;
  localparam int V_BC = 2;
  localparam int V_PA = 3;
  localparam int V_PB = 4;
  localparam int V_PC = 5;

  // dots: snom, sdenom, tnom, tdenom, unom, udenom (each denom as a negated sum)
  localparam int DL [6] = '{V_PA, V_PB, V_PA, V_PC, V_PB, V_PC};
  localparam int DR [6] = '{V_AB, V_AB, V_AC, V_AC, V_BC, V_BC};
  // crosses: n, pa x pb (vc), pb x pc (va), pc x pa (vb)
  localparam int XL [4] = '{V_AB, V_PA, V_PB, V_PC};
  localparam int XR [4] = '{V_AC, V_PB, V_PC, V_PA};
  localparam int NXT [3] = '{1, 2, 0};
  localparam int PRV [3] = '{2, 0, 1};

  typedef struct packed {
    logic [2:0][CW-1:0]         p;
    logic [2:0][CW-1:0]         a;
    logic [2:0][CW-1:0]         b;
    logic [2:0][CW-1:0]         c;
    logic [2:0][2:0][DW-1:0]    e;   // ab, ac, bc
  } carry_t;

  logic [7:0] vld;

  logic signed [CW-1:0] in_p [3];
  logic signed [CW-1:0] in_a [3];
  logic signed [CW-1:0] in_b [3];
  logic signed [CW-1:0] in_c [3];
  logic signed [DW-1:0] dv   [6][3];

  carry_t cp [7];

  logic signed [DW-1:0]  s1_vec [6][3];
  logic signed [PW-1:0]  s2_dp  [6][3];
  logic signed [PW-1:0]  s2_xp  [4][3][2];
  logic signed [SW-1:0]  s3_dot [6];
  logic signed [XW-1:0]  s3_x   [4][3];
  logic signed [SW-1:0]  s4_dot [6];
  logic signed [PPW-1:0] s4_pp  [3][3][4];
  logic signed [SW-1:0]  s5_dot [6];
  logic signed [TW-1:0]  s5_tp  [3][3];
  logic signed [SW-1:0]  s6_dot [6];
  logic signed [WW-1:0]  s6_tp  [3];
  logic signed [EW-1:0]  s6_ed  [3];
  logic signed [SW-1:0]  s7_dot [6];
  logic signed [WW-1:0]  s7_tp  [3];
  logic signed [EW-1:0]  s7_ed  [3];
  logic signed [WW-1:0]  s7_fd;
  logic [2:0]            s7_reg;
  logic [2:0]            reg_next;
  stctp_pkg::front_t     out_next;

  assign in_p = '{query.point_x,  query.point_y,  query.point_z};
  assign in_a = '{query.vert_a_x, query.vert_a_y, query.vert_a_z};
  assign in_b = '{query.vert_b_x, query.vert_b_y, query.vert_b_z};
  assign in_c = '{query.vert_c_x, query.vert_c_y, query.vert_c_z};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv[V_AB][i] = DW'(in_b[i]) - DW'(in_a[i]);
      dv[V_AC][i] = DW'(in_c[i]) - DW'(in_a[i]);
      dv[V_BC][i] = DW'(in_c[i]) - DW'(in_b[i]);
      dv[V_PA][i] = DW'(in_p[i]) - DW'(in_a[i]);
      dv[V_PB][i] = DW'(in_p[i]) - DW'(in_b[i]);
      dv[V_PC][i] = DW'(in_p[i]) - DW'(in_c[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[6:0], in_valid};
    end
  end

  // S1: differences
  always_ff @(posedge clk) begin
    s1_vec <= dv;
    for (int i = 0; i < 3; i++) begin
      cp[0].p[i]    <= in_p[i];
      cp[0].a[i]    <= in_a[i];
      cp[0].b[i]    <= in_b[i];
      cp[0].c[i]    <= in_c[i];
      cp[0].e[0][i] <= dv[V_AB][i];
      cp[0].e[1][i] <= dv[V_AC][i];
      cp[0].e[2][i] <= dv[V_BC][i];
    end
    for (int k = 1; k < 7; k++) begin
      cp[k] <= cp[k-1];
    end
  end

  // S2: 33x33 products; S3: dots and crosses
  always_ff @(posedge clk) begin
    for (int d = 0; d < 6; d++) begin
      for (int i = 0; i < 3; i++) begin
        s2_dp[d][i] <= PW'(s1_vec[DL[d]][i]) * PW'(s1_vec[DR[d]][i]);
      end
    end
    for (int x = 0; x < 4; x++) begin
      for (int i = 0; i < 3; i++) begin
        s2_xp[x][i][0] <= PW'(s1_vec[XL[x]][NXT[i]]) * PW'(s1_vec[XR[x]][PRV[i]]);
        s2_xp[x][i][1] <= PW'(s1_vec[XL[x]][PRV[i]]) * PW'(s1_vec[XR[x]][NXT[i]]);
      end
    end
    for (int d = 0; d < 6; d++) begin
      if (d % 2 == 1) begin
        s3_dot[d] <= SW'(0) - SW'(s2_dp[d][0]) - SW'(s2_dp[d][1]) - SW'(s2_dp[d][2]);
      end else begin
        s3_dot[d] <= SW'(s2_dp[d][0]) + SW'(s2_dp[d][1]) + SW'(s2_dp[d][2]);
      end
    end
    for (int x = 0; x < 4; x++) begin
      for (int i = 0; i < 3; i++) begin
        s3_x[x][i] <= XW'(s2_xp[x][i][0]) - XW'(s2_xp[x][i][1]);
      end
    end
  end

  // S4..S6: n . cr split into 35/32-bit limbs
  always_ff @(posedge clk) begin
    for (int t = 0; t < 3; t++) begin
      for (int i = 0; i < 3; i++) begin
        s4_pp[t][i][0] <= PPW'($signed(s3_x[0][i][XW-1:LW])) *
                          PPW'($signed(s3_x[t+1][i][XW-1:LW]));
        s4_pp[t][i][1] <= PPW'($signed(s3_x[0][i][XW-1:LW])) *
                          PPW'($signed({1'b0, s3_x[t+1][i][LW-1:0]}));
        s4_pp[t][i][2] <= PPW'($signed({1'b0, s3_x[0][i][LW-1:0]})) *
                          PPW'($signed(s3_x[t+1][i][XW-1:LW]));
        s4_pp[t][i][3] <= PPW'($signed({1'b0, s3_x[0][i][LW-1:0]})) *
                          PPW'($signed({1'b0, s3_x[t+1][i][LW-1:0]}));
        s5_tp[t][i] <= (TW'(s4_pp[t][i][0]) <<< (2 * LW)) +
                       ((TW'(s4_pp[t][i][1]) + TW'(s4_pp[t][i][2])) <<< LW) +
                       TW'(s4_pp[t][i][3]);
      end
      s6_tp[t] <= WW'(s5_tp[t][0]) + WW'(s5_tp[t][1]) + WW'(s5_tp[t][2]);
    end
    s4_dot   <= s3_dot;
    s5_dot   <= s4_dot;
    s6_dot   <= s5_dot;
    s6_ed[0] <= EW'(s5_dot[0]) + EW'(s5_dot[1]);
    s6_ed[1] <= EW'(s5_dot[4]) + EW'(s5_dot[5]);
    s6_ed[2] <= EW'(s5_dot[2]) + EW'(s5_dot[3]);
  end

  // S7: region by sign tests; vc = tp[0], va = tp[1], vb = tp[2]
  always_comb begin
    if (s6_dot[0] <= 0 && s6_dot[2] <= 0) begin
      reg_next = stctp_pkg::REG_VA;
    end else if (s6_dot[1] <= 0 && s6_dot[4] <= 0) begin
      reg_next = stctp_pkg::REG_VB;
    end else if (s6_dot[3] <= 0 && s6_dot[5] <= 0) begin
      reg_next = stctp_pkg::REG_VC;
    end else if (s6_tp[0] <= 0 && s6_dot[0] >= 0 && s6_dot[1] >= 0) begin
      reg_next = stctp_pkg::REG_EAB;
    end else if (s6_tp[1] <= 0 && s6_dot[4] >= 0 && s6_dot[5] >= 0) begin
      reg_next = stctp_pkg::REG_EBC;
    end else if (s6_tp[2] <= 0 && s6_dot[2] >= 0 && s6_dot[3] >= 0) begin
      reg_next = stctp_pkg::REG_ECA;
    end else begin
      reg_next = stctp_pkg::REG_FACE;
    end
  end

  always_ff @(posedge clk) begin
    s7_reg <= reg_next;
    s7_dot <= s6_dot;
    s7_tp  <= s6_tp;
    s7_ed  <= s6_ed;
    s7_fd  <= s6_tp[0] + s6_tp[1] + s6_tp[2];
  end

  // S8: operand select; zero denominator falls back to vertex a
  always_comb begin
    out_next        = '0;
    out_next.point  = cp[6].p;
    out_next.region = stctp_pkg::REG_VA;
    for (int i = 0; i < 3; i++) begin
      out_next.ax[i].den  = WW'(1);
      out_next.ax[i].base = $signed(cp[6].a[i]);
    end
    unique case (s7_reg)
      stctp_pkg::REG_VB: begin
        out_next.region = stctp_pkg::REG_VB;
        for (int i = 0; i < 3; i++) out_next.ax[i].base = $signed(cp[6].b[i]);
      end
      stctp_pkg::REG_VC: begin
        out_next.region = stctp_pkg::REG_VC;
        for (int i = 0; i < 3; i++) out_next.ax[i].base = $signed(cp[6].c[i]);
      end
      stctp_pkg::REG_EAB: begin
        if (s7_ed[0] != 0) begin
          out_next.region = stctp_pkg::REG_EAB;
          for (int i = 0; i < 3; i++) begin
            out_next.ax[i].w1  = WW'(s7_dot[0]);
            out_next.ax[i].d1  = $signed(cp[6].e[0][i]);
            out_next.ax[i].den = WW'(s7_ed[0]);
          end
        end
      end
      stctp_pkg::REG_EBC: begin
        if (s7_ed[1] != 0) begin
          out_next.region = stctp_pkg::REG_EBC;
          for (int i = 0; i < 3; i++) begin
            out_next.ax[i].base = $signed(cp[6].b[i]);
            out_next.ax[i].w1   = WW'(s7_dot[4]);
            out_next.ax[i].d1   = $signed(cp[6].e[2][i]);
            out_next.ax[i].den  = WW'(s7_ed[1]);
          end
        end
      end
      stctp_pkg::REG_ECA: begin
        if (s7_ed[2] != 0) begin
          out_next.region = stctp_pkg::REG_ECA;
          for (int i = 0; i < 3; i++) begin
            out_next.ax[i].w1  = WW'(s7_dot[2]);
            out_next.ax[i].d1  = $signed(cp[6].e[1][i]);
            out_next.ax[i].den = WW'(s7_ed[2]);
          end
        end
      end
      stctp_pkg::REG_FACE: begin
        if (s7_fd != 0) begin
          out_next.region = stctp_pkg::REG_FACE;
          for (int i = 0; i < 3; i++) begin
            out_next.ax[i].w1  = s7_tp[2];
            out_next.ax[i].d1  = $signed(cp[6].e[0][i]);
            out_next.ax[i].w2  = s7_tp[0];
            out_next.ax[i].d2  = $signed(cp[6].e[1][i]);
            out_next.ax[i].den = s7_fd;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    out <= out_next;
  end

  assign out_valid = vld[7];

endmodule

@@ src/stctp_axis.sv @@
module stctp_axis (
  input  logic                         clk,
  input  stctp_pkg::axis_t             ax_in,
  output logic signed [stctp_pkg::CW-1:0] coord
);

  localparam int CW = stctp_pkg::CW;
  localparam int DW = stctp_pkg::DW;
  localparam int PW = stctp_pkg::PW;
  localparam int WW = stctp_pkg::WW;
  localparam int LW = stctp_pkg::LW;
  localparam int NL = stctp_pkg::NL;
  localparam int NW = stctp_pkg::NW;
  localparam int QB = stctp_pkg::QB;
  localparam int QW = stctp_pkg::QW;
  localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

  logic signed [WW-1:0] wv [2];
  logic signed [DW-1:0] dv [2];
  logic signed [LW:0]   limb [2][NL];

  logic signed [PW-1:0] a_pp [2][NL];
  logic signed [WW-1:0] a_den, b_den, c_den;
  logic signed [CW-1:0] a_base, b_base, c_base, d_base;
  logic signed [NW-1:0] b_sum [2];
  logic signed [NW-1:0] sum_next [2];
  logic signed [NW-1:0] c_num;
  logic [NW-1:0]        d_nabs;
  logic [WW-1:0]        d_dabs;
  logic                 d_neg;

  logic [NW-1:0]        rem    [QB];
  logic [WW-1:0]        dab    [QB];
  logic [QB-1:0]        quo    [QB+1];
  logic                 neg_p  [QB+1];
  logic                 ovf_p  [QB+1];
  logic signed [CW-1:0] base_p [QB+1];

  logic signed [QW-1:0] f_q;
  logic                 f_ovf, f_neg;
  logic signed [CW-1:0] f_base;
  logic signed [QW:0]   g_sum;
  logic signed [CW-1:0] coord_next;

  assign wv = '{ax_in.w1, ax_in.w2};
  assign dv = '{ax_in.d1, ax_in.d2};

  // weights split into unsigned 32-bit limbs and a short signed top limb
  always_comb begin
    for (int j = 0; j < 2; j++) begin
      for (int l = 0; l < NL - 1; l++) begin
        limb[j][l] = $signed({1'b0, wv[j][l*LW +: LW]});
      end
      limb[j][NL-1] = (LW+1)'($signed(wv[j][WW-1:(NL-1)*LW]));
    end
  end

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      sum_next[j] = '0;
      for (int l = 0; l < NL; l++) begin
        sum_next[j] = sum_next[j] + (NW'(a_pp[j][l]) <<< (l * LW));
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 2; j++) begin
      for (int l = 0; l < NL; l++) begin
        a_pp[j][l] <= PW'(limb[j][l]) * PW'(dv[j]);
      end
    end
    a_den  <= ax_in.den;
    a_base <= ax_in.base;
    b_sum  <= sum_next;
    b_den  <= a_den;
    b_base <= a_base;
    c_num  <= b_sum[0] + b_sum[1];
    c_den  <= b_den;
    c_base <= b_base;
    d_nabs <= c_num[NW-1] ? NW'(-c_num) : NW'(c_num);
    d_dabs <= c_den[WW-1] ? WW'(-c_den) : WW'(c_den);
    d_neg  <= c_num[NW-1] ^ c_den[WW-1];
    d_base <= c_base;
    // quotient that needs more than QB bits saturates anyway
    rem[0]    <= d_nabs;
    dab[0]    <= d_dabs;
    quo[0]    <= '0;
    neg_p[0]  <= d_neg;
    ovf_p[0]  <= d_nabs >= (NW'(d_dabs) << QB);
    base_p[0] <= d_base;
  end

  // restoring divide, one quotient bit per stage
  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int BIT = QB - 1 - k;
    logic [NW-1:0] sh;
    logic          ge;

    assign sh = NW'(dab[k]) << BIT;
    assign ge = rem[k] >= sh;

    always_ff @(posedge clk) begin
      quo[k+1]    <= quo[k] | (QB'(ge) << BIT);
      neg_p[k+1]  <= neg_p[k];
      ovf_p[k+1]  <= ovf_p[k];
      base_p[k+1] <= base_p[k];
    end

    if (k < QB - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        rem[k+1] <= ge ? rem[k] - sh : rem[k];
        dab[k+1] <= dab[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    f_q    <= neg_p[QB] ? -$signed(QW'(quo[QB])) : $signed(QW'(quo[QB]));
    f_ovf  <= ovf_p[QB];
    f_neg  <= neg_p[QB];
    f_base <= base_p[QB];
  end

  always_comb begin
    g_sum = (QW+1)'(f_base) + (QW+1)'(f_q);
    if (f_ovf) begin
      coord_next = f_neg ? MINV : MAXV;
    end else if (g_sum > (QW+1)'(MAXV)) begin
      coord_next = MAXV;
    end else if (g_sum < (QW+1)'(MINV)) begin
      coord_next = MINV;
    end else begin
      coord_next = g_sum[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    coord <= coord_next;
  end

endmodule

@@ src/stctp_hit.sv @@
module stctp_hit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic [2:0][stctp_pkg::CW-1:0]        closest,
  input  logic [2:0][stctp_pkg::CW-1:0]        point,
  input  logic [2:0]                           region,
  input  logic [stctp_pkg::RSQW-1:0]           rsq,
  output logic                                 out_valid,
  output stctp_pkg::result_t                   result
);

  localparam int CW = stctp_pkg::CW;
  localparam int DW = stctp_pkg::DW;
  localparam int PW = stctp_pkg::PW;

  logic [1:0]           vld;
  logic signed [DW-1:0] h1_d [3];
  logic signed [PW-1:0] h2_sq [3];
  logic [2:0][CW-1:0]   h1_q, h2_q;
  logic [2:0]           h1_r, h2_r;
  logic [PW+1:0]        dsq;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      vld       <= {vld[0], in_valid};
      out_valid <= vld[1];
    end
  end

  assign dsq = (PW+2)'(h2_sq[0]) + (PW+2)'(h2_sq[1]) + (PW+2)'(h2_sq[2]);

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      h1_d[i]  <= DW'($signed(closest[i])) - DW'($signed(point[i]));
      h2_sq[i] <= PW'(h1_d[i]) * PW'(h1_d[i]);
    end
    h1_q <= closest;
    h1_r <= region;
    h2_q <= h1_q;
    h2_r <= h1_r;
    result.closest_x <= $signed(h2_q[0]);
    result.closest_y <= $signed(h2_q[1]);
    result.closest_z <= $signed(h2_q[2]);
    result.region    <= h2_r;
    result.hit       <= dsq <= (PW+2)'(rsq);
  end

endmodule

@@ src/sphere_triangle_closest_point.sv @@
// Closest point on a triangle to a sphere centre, with a radius hit test.
// One item (query point and three vertices, signed Q16.16) is taken on any
// cycle with start high; busy never rises, so items may arrive every cycle.
// Each result appears for one cycle with done high, in item order; the
// receiver cannot stall and must take it then.
// The pipeline has three parts: an 8-stage geometry front end (dot and
// cross products, triple products split into limbs, region select), a
// per-axis divider pipeline of 40 stages (33 of them are the one-bit-per-
// stage restoring divide of the weighted sum by the denominator), and a
// 3-stage squared-distance compare. The user must write the sphere radius
// through cfg_we/cfg_data only while no item is in flight; the block does not
// enforce this. Its square is registered in the cycle after the radius changes.
module sphere_triangle_closest_point (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  stctp_pkg::query_t              query,
  input  logic                           cfg_we,
  input  logic [stctp_pkg::RW-1:0]       cfg_data,
  output logic                           done,
  output stctp_pkg::result_t             result
);

  localparam int CW  = stctp_pkg::CW;
  localparam int LAT = stctp_pkg::AXIS_LAT;

  logic [stctp_pkg::RW-1:0]   radius;
  logic [stctp_pkg::RSQW-1:0] rsq;

  logic                 front_valid;
  stctp_pkg::front_t    front;

  // valid, region and query point ride alongside the divider pipelines
  logic [LAT-1:0]       dl_valid;
  logic [2:0]           dl_region [LAT];
  logic [2:0][CW-1:0]   dl_point  [LAT];

  logic [2:0][CW-1:0]   closest;

  // fully pipelined: never refuses an item
  assign busy = 1'b0;

  // radius register and its square
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= '0;
      rsq    <= '0;
    end else begin
      if (cfg_we) begin
        radius <= cfg_data;
      end
      rsq <= stctp_pkg::RSQW'(radius) * stctp_pkg::RSQW'(radius);
    end
  end

  stctp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .query     (query),
    .out_valid (front_valid),
    .out       (front)
  );

  // one divider pipeline per axis
  for (genvar i = 0; i < 3; i++) begin : g_axis
    logic signed [CW-1:0] coord;

    stctp_axis u_axis (
      .clk   (clk),
      .ax_in (front.ax[i]),
      .coord (coord)
    );

    assign closest[i] = coord;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dl_valid <= '0;
    end else begin
      dl_valid <= {dl_valid[LAT-2:0], front_valid};
    end
  end

  always_ff @(posedge clk) begin
    dl_region[0] <= front.region;
    dl_point[0]  <= front.point;
    for (int k = 1; k < LAT; k++) begin
      dl_region[k] <= dl_region[k-1];
      dl_point[k]  <= dl_point[k-1];
    end
  end

  stctp_hit u_hit (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dl_valid[LAT-1]),
    .closest   (closest),
    .point     (dl_point[LAT-1]),
    .region    (dl_region[LAT-1]),
    .rsq       (rsq),
    .out_valid (done),
    .result    (result)
  );

`ifndef SYNTH
  // every accepted item comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(stctp_pkg::TOTAL_LAT) done)
    else $error("result missing at fixed latency");

  // vertex regions carry no weights into the dividers (checked on w1 of every axis and w2 of axis 0)
  a_vertex_zero_weight: assert property (@(posedge clk) disable iff (rst)
    (front_valid && (front.region == stctp_pkg::REG_VA ||
                     front.region == stctp_pkg::REG_VB ||
                     front.region == stctp_pkg::REG_VC)) |->
    (front.ax[0].w1 == 0 && front.ax[0].w2 == 0 &&
     front.ax[1].w1 == 0 && front.ax[2].w1 == 0))
    else $error("vertex region with nonzero weight");

  // a zero denominator never reaches the dividers
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    front_valid |-> (front.ax[0].den != 0 && front.ax[1].den != 0 &&
                     front.ax[2].den != 0))
    else $error("zero denominator into divider");
`endif

endmodule
